// ===== rtl/rgcb_pkg.sv =====
// ----------------------------------------------------------------------------
// rgcb_pkg
// Shared types, constants and helpers for the cluster grid binner.
// ----------------------------------------------------------------------------
`default_nettype none

package rgcb_pkg;

  localparam int COORD_W   = 16;
  localparam int TAG_W     = 16;
  localparam int CELL_W    = 10;
  localparam int RAD_W     = 14;
  localparam int MAP_W     = 16;
  localparam int PITCH_W   = 15;  // radius*4/3 never exceeds 21844
  localparam int CNT_W     = 18;  // doubled grid index plus offset
  localparam int SLOTS     = 9;
  localparam int LANES     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int GRID_CELLS_DEF = 1024;
  localparam int FIFO_DEPTH_DEF = 32;

  // Lanes of the divider chain
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_W = 2;
  localparam int LANE_H = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 14'd48;
  localparam logic [MAP_W-1:0] MAP_RST    = 16'd1024;

  // x/3 == (x * 0xAAAB) >> 17 for every 16-bit x
  localparam logic [15:0] THIRD_MUL   = 16'hAAAB;
  localparam int          THIRD_SHIFT = 17;

  // Slot order of the append burst
  localparam int SLOT_UL = 0;
  localparam int SLOT_LL = 1;
  localparam int SLOT_L  = 2;
  localparam int SLOT_UR = 3;
  localparam int SLOT_LR = 4;
  localparam int SLOT_R  = 5;
  localparam int SLOT_U  = 6;
  localparam int SLOT_D  = 7;
  localparam int SLOT_C  = 8;

  localparam logic [1:0] OFS_NEG  = 2'b11;
  localparam logic [1:0] OFS_ZERO = 2'b00;
  localparam logic [1:0] OFS_POS  = 2'b01;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [TAG_W-1:0]   client_id;
    logic               changed;
  } rgcb_in_t;

  typedef struct packed {
    logic [CELL_W-1:0] home_x;
    logic [CELL_W-1:0] home_y;
    logic [CELL_W-1:0] target_x;
    logic [CELL_W-1:0] target_y;
    logic              append;
    logic [TAG_W-1:0]  client_tag;
    logic              error;
    logic              last;
  } rgcb_out_t;

  // Item info travelling alongside the divider lanes
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic               changed;
    logic [RAD_W-1:0]   radius;
    logic [PITCH_W-1:0] pitch;
  } side_t;

  // Classified item waiting for the result sequencer
  typedef struct packed {
    logic              err;
    logic              chg;
    logic [CELL_W-1:0] home_x;
    logic [CELL_W-1:0] home_y;
    logic [TAG_W-1:0]  tag;
    logic [SLOTS-1:0]  mask;
  } entry_t;

  function automatic logic [1:0] slot_dx(input logic [3:0] s);
    logic [1:0] d;
    case (s)
      4'd0, 4'd1, 4'd2: d = OFS_NEG;
      4'd3, 4'd4, 4'd5: d = OFS_POS;
      default:          d = OFS_ZERO;
    endcase
    return d;
  endfunction

  function automatic logic [1:0] slot_dy(input logic [3:0] s);
    logic [1:0] d;
    case (s)
      4'd0, 4'd3, 4'd6: d = OFS_NEG;
      4'd1, 4'd4, 4'd7: d = OFS_POS;
      default:          d = OFS_ZERO;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rgcb_div_cell.sv =====
// ----------------------------------------------------------------------------
// rgcb_div_cell
// One restoring-division step on four lanes: settles quotient bit BIT.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcb_div_cell #(
  parameter int BIT = 0
) (
  input  wire                                                     clk,
  input  wire                                                     rst_n,
  input  rgcb_pkg::side_t                                         side_in,
  input  wire  [rgcb_pkg::LANES-1:0][rgcb_pkg::COORD_W-1:0]       num_in,
  input  wire  [rgcb_pkg::LANES-1:0][rgcb_pkg::COORD_W-1:0]       quo_in,
  input  wire  [rgcb_pkg::LANES-1:0][rgcb_pkg::PITCH_W-1:0]       rem_in,
  output rgcb_pkg::side_t                                         side_out,
  output logic [rgcb_pkg::LANES-1:0][rgcb_pkg::COORD_W-1:0]       num_out,
  output logic [rgcb_pkg::LANES-1:0][rgcb_pkg::COORD_W-1:0]       quo_out,
  output logic [rgcb_pkg::LANES-1:0][rgcb_pkg::PITCH_W-1:0]       rem_out
);
  import rgcb_pkg::*;

  side_t                             side_r;
  logic [LANES-1:0][COORD_W-1:0]     num_r, quo_r, quo_nxt;
  logic [LANES-1:0][PITCH_W-1:0]     rem_r, rem_nxt;
  logic [PITCH_W:0]                  trial;
  logic [PITCH_W:0]                  dsor;
  logic [PITCH_W:0]                  diff;

  always_comb begin
    dsor = {1'b0, side_in.pitch};
    trial = '0;
    diff = '0;
    for (int l = 0; l < LANES; l++) begin
      trial = {rem_in[l], num_in[l][BIT]};
      diff = trial - dsor;
      quo_nxt[l] = quo_in[l];
      if (trial >= dsor) begin
        quo_nxt[l][BIT] = 1'b1;
        rem_nxt[l] = diff[PITCH_W-1:0];
      end else begin
        rem_nxt[l] = trial[PITCH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_in;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign side_out = side_r;
  assign num_out  = num_r;
  assign quo_out  = quo_r;
  assign rem_out  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/rgcb_emit.sv =====
// ----------------------------------------------------------------------------
// rgcb_emit
// Queue of classified items and the sequencer that plays out their results.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcb_emit #(
  parameter int DEPTH = rgcb_pkg::FIFO_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr_en,
  input  rgcb_pkg::entry_t    wr_entry,
  output logic                out_valid,
  output rgcb_pkg::rgcb_out_t out_data,
  output logic                done
);
  import rgcb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_TOP = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_TOP = CW'(DEPTH);

  entry_t            mem [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  entry_t            head_r, cur_r, cur_nxt;
  logic              act_r, act_nxt;
  logic [SLOTS-1:0]  msk_r, msk_nxt, low, rest;
  logic              fin, load;
  logic [3:0]        slot;
  logic [1:0]        dx, dy;
  rgcb_out_t         res, out_r;
  logic              out_valid_r;

  // Head is fetched for the next read pointer; a write to that slot passes through
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_entry;
    end
    if (wr_en && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wr_entry;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  always_comb begin
    low  = msk_r & (~msk_r + 1'b1);
    rest = msk_r & ~low;
    fin  = act_r && (rest == '0);
    load = (cnt_r != '0) && (!act_r || fin);

    act_nxt = act_r;
    msk_nxt = msk_r;
    cur_nxt = cur_r;
    if (load) begin
      act_nxt = 1'b1;
      msk_nxt = head_r.mask;
      cur_nxt = head_r;
    end else if (act_r) begin
      act_nxt = !fin;
      msk_nxt = rest;
    end

    wr_ptr_nxt = wr_en ? ((wr_ptr_r == PTR_TOP) ? '0 : wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = load ? ((rd_ptr_r == PTR_TOP) ? '0 : rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt = cnt_r + CW'(wr_en) - CW'(load);
  end

  // Slot of the lowest pending bit
  always_comb begin
    slot = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (low[s]) slot = 4'(s);
    end
    dx = slot_dx(slot);
    dy = slot_dy(slot);

    res.client_tag = cur_r.tag;
    res.last       = (rest == '0);
    if (cur_r.err) begin
      res.home_x   = '0;
      res.home_y   = '0;
      res.target_x = '0;
      res.target_y = '0;
      res.append   = 1'b0;
      res.error    = 1'b1;
    end else begin
      res.home_x   = cur_r.home_x;
      res.home_y   = cur_r.home_y;
      res.target_x = cur_r.home_x + {{(CELL_W-2){dx[1]}}, dx};
      res.target_y = cur_r.home_y + {{(CELL_W-2){dy[1]}}, dy};
      res.append   = cur_r.chg;
      res.error    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      out_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    msk_r <= msk_nxt;
    cur_r <= cur_nxt;
    out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign done      = out_valid_r && out_r.last;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cnt_r != CNT_TOP))
    else $error("result queue written while full");

  a_active_mask: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (msk_r != '0))
    else $error("sequencer active with no pending slot");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.error) |-> (out_r.last && !out_r.append))
    else $error("error result not a lone final result");

endmodule

`default_nettype wire

// ===== rtl/radius_grid_cluster_binner.sv =====
// ----------------------------------------------------------------------------
// radius_grid_cluster_binner
// Places a point on the cluster grid and issues home cell and append commands.
// ----------------------------------------------------------------------------
// A point is taken on start while busy is low. Its results appear on out_data
// one per cycle, each for exactly one cycle with out_valid high; there is no
// way to hold them off. An item gives one result (no change, or an error) or
// up to nine append commands; the result port sets the sustained rate. The
// path in runs through one pitch stage, a chain of 16 divider cells (one
// quotient bit each), a squaring stage, the classify/queue stage and the
// result sequencer. Up to FIFO_DEPTH items may be in flight; busy is raised
// while that credit is all in use. Registers are written on cfg_we; the user
// must write them only while the block idles; the block does not enforce it.
`default_nettype none

module radius_grid_cluster_binner #(
  parameter int GRID_CELLS = rgcb_pkg::GRID_CELLS_DEF,
  parameter int FIFO_DEPTH = rgcb_pkg::FIFO_DEPTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  rgcb_pkg::rgcb_in_t                 in_data,
  output logic                               out_valid,
  output rgcb_pkg::rgcb_out_t                out_data,
  input  wire                                cfg_we,
  input  wire  [rgcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [rgcb_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import rgcb_pkg::*;

  localparam int OW = $clog2(FIFO_DEPTH + 1);
  localparam logic [OW-1:0]    OCC_TOP  = OW'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] GRID_CAP = CNT_W'(GRID_CELLS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

  // ---- configuration registers ----
  logic [RAD_W-1:0] radius_r;
  logic [MAP_W-1:0] map_w_r, map_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      map_w_r  <= MAP_RST;
      map_h_r  <= MAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:     radius_r <= cfg_wdata[RAD_W-1:0];
        REG_MAP_WIDTH:  map_w_r  <= cfg_wdata[MAP_W-1:0];
        REG_MAP_HEIGHT: map_h_r  <= cfg_wdata[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- credit: items accepted whose final result is not yet out ----
  logic          accept, done;
  logic [OW-1:0] occ_r, occ_nxt;

  assign accept  = start && !busy;
  assign busy    = (occ_r == OCC_TOP);
  assign occ_nxt = occ_r + OW'(accept) - OW'(done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // ---- stage 0: pitch = radius*4/3 via reciprocal multiply ----
  logic [31:0] third_prod;
  side_t       side_c [COORD_W+1];
  logic [LANES-1:0][COORD_W-1:0] num_c [COORD_W+1];
  logic [LANES-1:0][COORD_W-1:0] quo_c [COORD_W+1];
  logic [LANES-1:0][PITCH_W-1:0] rem_c [COORD_W+1];
  side_t       s0_side_r;
  logic [LANES-1:0][COORD_W-1:0] s0_num_r;

  assign third_prod = {radius_r, 2'b00} * THIRD_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_side_r.valid <= 1'b0;
    end else begin
      s0_side_r.valid   <= accept;
      s0_side_r.tag     <= in_data.client_id;
      s0_side_r.changed <= in_data.changed;
      s0_side_r.radius  <= radius_r;
      s0_side_r.pitch   <= third_prod[THIRD_SHIFT +: PITCH_W];
    end
  end

  always_ff @(posedge clk) begin
    s0_num_r[LANE_X] <= in_data.pos_x;
    s0_num_r[LANE_Y] <= in_data.pos_y;
    s0_num_r[LANE_W] <= map_w_r;
    s0_num_r[LANE_H] <= map_h_r;
  end

  assign side_c[0] = s0_side_r;
  assign num_c[0]  = s0_num_r;
  assign quo_c[0]  = '0;
  assign rem_c[0]  = '0;

  // ---- divider chain, most significant quotient bit first ----
  for (genvar k = 0; k < COORD_W; k++) begin : g_cell
    rgcb_div_cell #(.BIT(COORD_W - 1 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .side_in  (side_c[k]),
      .num_in   (num_c[k]),
      .quo_in   (quo_c[k]),
      .rem_in   (rem_c[k]),
      .side_out (side_c[k+1]),
      .num_out  (num_c[k+1]),
      .quo_out  (quo_c[k+1]),
      .rem_out  (rem_c[k+1])
    );
  end

  // ---- stage 1: squared corner distances and radius squared ----
  side_t               tail;
  logic [PITCH_W-1:0]  dr, db;
  side_t               s1_side_r;
  logic [COORD_W-1:0]  s1_qx_r, s1_qy_r, s1_qw_r, s1_qh_r;
  logic [2*PITCH_W-1:0] dl2_r, dr2_r, dt2_r, db2_r;
  logic [2*RAD_W-1:0]  r2_r;

  assign tail = side_c[COORD_W];
  assign dr   = tail.pitch - rem_c[COORD_W][LANE_X];
  assign db   = tail.pitch - rem_c[COORD_W][LANE_Y];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.valid <= 1'b0;
    end else begin
      s1_side_r <= tail;
    end
  end

  always_ff @(posedge clk) begin
    s1_qx_r <= quo_c[COORD_W][LANE_X];
    s1_qy_r <= quo_c[COORD_W][LANE_Y];
    s1_qw_r <= quo_c[COORD_W][LANE_W];
    s1_qh_r <= quo_c[COORD_W][LANE_H];
    dl2_r   <= rem_c[COORD_W][LANE_X] * rem_c[COORD_W][LANE_X];
    dt2_r   <= rem_c[COORD_W][LANE_Y] * rem_c[COORD_W][LANE_Y];
    dr2_r   <= dr * dr;
    db2_r   <= db * db;
    r2_r    <= tail.radius * tail.radius;
  end

  // ---- stage 2: near corners, home cell, bounds, burst mask ----
  logic [2*PITCH_W:0] r2x;
  logic               ul, ll, ur, lr, near;
  logic [1:0]         offx, offy;
  logic [CNT_W-1:0]   hx, hy, cols_raw, rows_raw, cols, rows;
  logic               lft, rgt, up, dn, err;
  entry_t             ent;

  always_comb begin
    r2x = (2*PITCH_W+1)'(r2_r);
    ul = ({1'b0, dl2_r} + {1'b0, dt2_r}) <= r2x;
    ll = ({1'b0, dl2_r} + {1'b0, db2_r}) <= r2x;
    ur = ({1'b0, dr2_r} + {1'b0, dt2_r}) <= r2x;
    lr = ({1'b0, dr2_r} + {1'b0, db2_r}) <= r2x;

    near = 1'b1;
    if (ul && ll && ur && lr) begin
      offx = 2'd1; offy = 2'd1;
    end else if (ul && ll) begin
      offx = 2'd0; offy = 2'd1;
    end else if (ur && lr) begin
      offx = 2'd2; offy = 2'd1;
    end else if (ul && ur) begin
      offx = 2'd1; offy = 2'd0;
    end else if (ll && lr) begin
      offx = 2'd1; offy = 2'd2;
    end else if (ul) begin
      offx = 2'd0; offy = 2'd0;
    end else if (ll) begin
      offx = 2'd0; offy = 2'd2;
    end else if (ur) begin
      offx = 2'd2; offy = 2'd0;
    end else if (lr) begin
      offx = 2'd2; offy = 2'd2;
    end else begin
      offx = 2'd0; offy = 2'd0;
      near = 1'b0;
    end

    hx = {1'b0, s1_qx_r, 1'b0} + CNT_W'(offx);
    hy = {1'b0, s1_qy_r, 1'b0} + CNT_W'(offy);

    // (extent/pitch + 2)*2 - 1, capped at the grid size
    cols_raw = {1'b0, s1_qw_r, 1'b0} + CNT_THREE;
    rows_raw = {1'b0, s1_qh_r, 1'b0} + CNT_THREE;
    cols = (cols_raw > GRID_CAP) ? GRID_CAP : cols_raw;
    rows = (rows_raw > GRID_CAP) ? GRID_CAP : rows_raw;

    err = (s1_side_r.pitch == '0) || !near || (hx >= cols) || (hy >= rows);

    lft = (hx != '0);
    rgt = (hx < cols - CNT_ONE);
    up  = (hy != '0);
    dn  = (hy < rows - CNT_ONE);

    ent.err    = err;
    ent.chg    = s1_side_r.changed;
    ent.home_x = hx[CELL_W-1:0];
    ent.home_y = hy[CELL_W-1:0];
    ent.tag    = s1_side_r.tag;
    ent.mask   = '0;
    ent.mask[SLOT_C] = 1'b1;
    if (!err && s1_side_r.changed) begin
      ent.mask[SLOT_UL] = lft && up;
      ent.mask[SLOT_LL] = lft && dn;
      ent.mask[SLOT_L]  = lft;
      ent.mask[SLOT_UR] = rgt && up;
      ent.mask[SLOT_LR] = rgt && dn;
      ent.mask[SLOT_R]  = rgt;
      ent.mask[SLOT_U]  = up;
      ent.mask[SLOT_D]  = dn;
    end
  end

  rgcb_emit #(.DEPTH(FIFO_DEPTH)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (s1_side_r.valid),
    .wr_entry  (ent),
    .out_valid (out_valid),
    .out_data  (out_data),
    .done      (done)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_TOP)
    else $error("in-flight count beyond queue depth");

  a_out_owned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (occ_r != '0))
    else $error("result shown with no item in flight");

  a_queue_owned: assert property (@(posedge clk) disable iff (!rst_n)
    s1_side_r.valid |-> (occ_r != '0))
    else $error("classified item with no credit taken");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cluster grid binner: points go in through a
// start/busy port, and each result is checked against a predictor kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rgcb_pkg::*;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // DUT ports
  logic      start = 1'b0;
  logic      busy;
  rgcb_in_t  in_data = '0;
  logic      out_valid;
  rgcb_out_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  radius_grid_cluster_binner u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor's copy of the registers
  int unsigned pm_radius = 48;
  int unsigned pm_width  = 1024;
  int unsigned pm_height = 1024;

  rgcb_in_t  point_q[$];     // points waiting to be driven
  rgcb_out_t cmd_expect_q[$]; // commands predicted, oldest first
  int  errors = 0;
  int  n_points = 0;
  int  n_cmds = 0;
  int  n_err_cmds = 0;
  longint cycle = 0;
  int  burst_left = 0;
  int  gap_left = 0;

  function automatic rgcb_out_t mk_cmd(int hx, int hy, int tx, int ty, bit app,
                                       logic [15:0] tag, bit err, bit lst);
    rgcb_out_t r;
    r.home_x = hx[CELL_W-1:0];
    r.home_y = hy[CELL_W-1:0];
    r.target_x = tx[CELL_W-1:0];
    r.target_y = ty[CELL_W-1:0];
    r.append = app;
    r.client_tag = tag;
    r.error = err;
    r.last = lst;
    return r;
  endfunction

  function automatic longint unsigned grid_count(longint unsigned ext,
                                                 longint unsigned p);
    longint unsigned n;
    n = (ext / p + 2) * 2 - 1;
    return (n > 1024) ? 1024 : n;
  endfunction

  // Work out the commands one point produces and queue them
  task automatic bin_point(rgcb_in_t p);
    longint unsigned pitch, gx, gy, dl, dr, dt, db, r2, cols, rows, hx, hy;
    bit ul, ll, ur, lr, ok;
    logic [15:0] tag;
    tag = p.client_id;
    pitch = longint'(pm_radius) * 4 / 3;
    ok = 1'b1;
    if (pitch == 0) ok = 1'b0;
    else begin
      gx = p.pos_x / pitch;
      gy = p.pos_y / pitch;
      dl = p.pos_x - gx * pitch;
      dr = gx * pitch + pitch - p.pos_x;
      dt = p.pos_y - gy * pitch;
      db = gy * pitch + pitch - p.pos_y;
      dl *= dl; dr *= dr; dt *= dt; db *= db;
      r2 = longint'(pm_radius) * pm_radius;
      ul = dl + dt <= r2;
      ll = dl + db <= r2;
      ur = dr + dt <= r2;
      lr = dr + db <= r2;
      gx *= 2; gy *= 2;
      // priority: middle, left, right, top, bottom, then single corners
      if (ul && ll && ur && lr) begin hx = gx + 1; hy = gy + 1; end
      else if (ul && ll) begin hx = gx; hy = gy + 1; end
      else if (ur && lr) begin hx = gx + 2; hy = gy + 1; end
      else if (ul && ur) begin hx = gx + 1; hy = gy; end
      else if (ll && lr) begin hx = gx + 1; hy = gy + 2; end
      else if (ul) begin hx = gx; hy = gy; end
      else if (ll) begin hx = gx; hy = gy + 2; end
      else if (ur) begin hx = gx + 2; hy = gy; end
      else if (lr) begin hx = gx + 2; hy = gy + 2; end
      else ok = 1'b0;
      if (ok) begin
        cols = grid_count(pm_width, pitch);
        rows = grid_count(pm_height, pitch);
        if (hx >= cols || hy >= rows) ok = 1'b0;
      end
    end
    if (!ok) begin
      cmd_expect_q.push_back(mk_cmd(0, 0, 0, 0, 0, tag, 1, 1));
      return;
    end
    if (!p.changed) begin
      cmd_expect_q.push_back(mk_cmd(hx, hy, hx, hy, 0, tag, 0, 1));
      return;
    end
    // neighbour appends in fixed order, centre last
    if (hx > 0) begin
      if (hy > 0) cmd_expect_q.push_back(mk_cmd(hx, hy, hx-1, hy-1, 1, tag, 0, 0));
      if (hy < rows-1) cmd_expect_q.push_back(mk_cmd(hx, hy, hx-1, hy+1, 1, tag, 0, 0));
      cmd_expect_q.push_back(mk_cmd(hx, hy, hx-1, hy, 1, tag, 0, 0));
    end
    if (hx < cols-1) begin
      if (hy > 0) cmd_expect_q.push_back(mk_cmd(hx, hy, hx+1, hy-1, 1, tag, 0, 0));
      if (hy < rows-1) cmd_expect_q.push_back(mk_cmd(hx, hy, hx+1, hy+1, 1, tag, 0, 0));
      cmd_expect_q.push_back(mk_cmd(hx, hy, hx+1, hy, 1, tag, 0, 0));
    end
    if (hy > 0) cmd_expect_q.push_back(mk_cmd(hx, hy, hx, hy-1, 1, tag, 0, 0));
    if (hy < rows-1) cmd_expect_q.push_back(mk_cmd(hx, hy, hx, hy+1, 1, tag, 0, 0));
    cmd_expect_q.push_back(mk_cmd(hx, hy, hx, hy, 1, tag, 0, 1));
  endtask

  // Driver: bursts and gaps; start stays high across back-to-back transfers.
  // Prediction happens at the edge that accepts the transfer.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      bin_point(in_data);
      n_points++;
    end
    if (start && busy) begin
      // transfer not yet taken; hold everything
    end else if (point_q.size() == 0 || !rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else begin
      in_data <= point_q.pop_front();
      start <= 1'b1;
      if (burst_left > 0) burst_left--;
      else begin
        burst_left = $urandom_range(0, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      end
    end
  end

  // Monitor: results cannot be held, so every strobed cycle is one transfer
  always @(posedge clk) begin
    cycle++;
    if (out_valid && rst_n) begin
      rgcb_out_t e;
      if (cmd_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %p", $time, out_data);
      end else begin
        e = cmd_expect_q.pop_front();
        n_cmds++;
        if (out_data.error) n_err_cmds++;
        if (out_data !== e) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
        end
      end
    end
    if (cycle > 400000) begin
      $display("%0t: timeout with %0d results outstanding", $time, cmd_expect_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Wait until the sender has drained its queue and every result has arrived
  task automatic drain();
    while (point_q.size() != 0 || start) @(posedge clk);
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DAT_W-1:0];
    case (idx)
      REG_RADIUS:     pm_radius = val & 16'h3FFF;
      REG_MAP_WIDTH:  pm_width = val & 16'hFFFF;
      default:        pm_height = val & 16'hFFFF;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic rgcb_in_t mk_point(int x, int y, int id, bit chg);
    rgcb_in_t p;
    p.pos_x = x[15:0];
    p.pos_y = y[15:0];
    p.client_id = id[15:0];
    p.changed = chg;
    return p;
  endfunction

  // Random point: mostly near grid features of the current pitch
  function automatic rgcb_in_t rand_point();
    int unsigned pitch, x, y;
    pitch = pm_radius * 4 / 3;
    if (pitch == 0 || $urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, 65535);
      y = $urandom_range(0, 65535);
    end else begin
      x = pitch * $urandom_range(0, 20) + $urandom_range(0, pitch);
      y = pitch * $urandom_range(0, 20) + $urandom_range(0, pitch);
    end
    return mk_point(x, y, $urandom, $urandom_range(0, 3) != 0);
  endfunction

  task automatic random_phase(int n);
    repeat (n) point_q.push_back(rand_point());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config (pitch 64), corners, middle, edges, out-of-grid points
    point_q.push_back(mk_point(0, 0, 16'h0000, 1));          // top-left corner
    point_q.push_back(mk_point(32, 32, 16'hFFFF, 1));        // centre of a square
    point_q.push_back(mk_point(32, 32, 16'h1234, 0));        // no change
    point_q.push_back(mk_point(5, 32, 16'h0001, 1));         // left pair
    point_q.push_back(mk_point(60, 32, 16'h0002, 1));        // right pair
    point_q.push_back(mk_point(32, 5, 16'h0003, 1));         // top pair
    point_q.push_back(mk_point(32, 60, 16'h0004, 1));        // bottom pair
    point_q.push_back(mk_point(63, 63, 16'h0005, 1));        // lower-right corner
    point_q.push_back(mk_point(1000, 1000, 16'h0006, 1));    // far edge of grid
    point_q.push_back(mk_point(65535, 65535, 16'h5A5A, 1));  // beyond grid
    point_q.push_back(mk_point(65535, 0, 16'hA5A5, 0));
    point_q.push_back(mk_point(0, 65535, 16'h8000, 1));
    drain();

    // Small radius: the centre of a square is still near every corner
    write_reg(REG_RADIUS, 3);     // pitch 4
    point_q.push_back(mk_point(2, 2, 16'h0010, 1));
    point_q.push_back(mk_point(1, 2, 16'h0011, 1));
    point_q.push_back(mk_point(4, 4, 16'h0012, 0));
    drain();

    // Zero radius, then the extremes of radius and map size
    write_reg(REG_RADIUS, 0);
    point_q.push_back(mk_point(10, 10, 16'h0020, 1));
    drain();
    write_reg(REG_RADIUS, 16383);
    write_reg(REG_MAP_WIDTH, 65535);
    write_reg(REG_MAP_HEIGHT, 0);
    point_q.push_back(mk_point(65535, 0, 16'h0030, 1));
    point_q.push_back(mk_point(0, 0, 16'h0031, 1));
    point_q.push_back(mk_point(21844, 100, 16'h0032, 1));
    drain();
    write_reg(REG_RADIUS, 1);     // pitch 1
    write_reg(REG_MAP_WIDTH, 0);
    write_reg(REG_MAP_HEIGHT, 65535);
    point_q.push_back(mk_point(0, 0, 16'h0040, 1));
    point_q.push_back(mk_point(1, 700, 16'h0041, 1));
    drain();

    // Random phases over several settings; drain() doubles as a sender pause
    write_reg(REG_RADIUS, 48);
    write_reg(REG_MAP_WIDTH, 1024);
    write_reg(REG_MAP_HEIGHT, 1024);
    random_phase(70);
    write_reg(REG_RADIUS, 12);
    write_reg(REG_MAP_WIDTH, 300);
    write_reg(REG_MAP_HEIGHT, 150);
    random_phase(60);
    write_reg(REG_RADIUS, $urandom_range(1, 16383));
    write_reg(REG_MAP_WIDTH, $urandom_range(0, 65535));
    write_reg(REG_MAP_HEIGHT, $urandom_range(0, 65535));
    random_phase(50);
    write_reg(REG_RADIUS, 100);
    write_reg(REG_MAP_WIDTH, 65535);
    write_reg(REG_MAP_HEIGHT, 65535);
    random_phase(70);

    $display("Ran %0d points over several radius and map settings,", n_points);
    $display("checked %0d results, %0d of them error results.", n_cmds, n_err_cmds);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rgcb_pkg.sv
rtl/rgcb_div_cell.sv
rtl/rgcb_emit.sv
rtl/radius_grid_cluster_binner.sv
tb/sv/tb_top.sv
